[rtl/pcc_pkg.sv]
`timescale 1ns / 1ps
// pcc_pkg: constants, register indexes and crc helper for the pattern checker
// no dependencies

package pcc_pkg;

   localparam logic [31:0] LCG_MUL  = 32'd1664525;
   localparam logic [31:0] LCG_ADD  = 32'd1013904223;
   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

   localparam logic [15:0] WORD_COUNT_RESET = 16'd4096;

   typedef enum logic [0:0] {
      CSR_PATTERN_BASE = 1'b0,
      CSR_WORD_COUNT   = 1'b1
   } csr_index_type;

   // reflected crc32 over one byte, eight shift steps
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int k = 0; k < 8; k++) begin
         c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
      end
      return c;
   endfunction

endpackage

[rtl/pattern_check_with_crc32_unit.sv]
`timescale 1ns / 1ps
// pattern_check_with_crc32_unit: top level of the memory pattern checker
// depends on pcc_pkg and pcc_crc32

// Takes one read-back word per cycle, checks it against the expected sequence
// (pattern_base + i) * 1664525 + 1013904223 and folds it into a crc32. Every
// word is fully handled in the cycle it is accepted: compare, crc network and
// run state update sit between the request port and the run registers, so a
// word can be accepted on every clock. The last word of a run loads the
// output register, whose result appears in the next cycle. req_ready drops only
// when the next word ends a run while the previous result is still waiting;
// words that do not end a run are taken regardless of the result channel.
// Write csr registers only while no transaction is in flight.

module pattern_check_with_crc32_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_word_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_fail_index,
   output logic        rsp_mismatch,
   output logic [31:0] rsp_got_value,
   output logic [31:0] rsp_want_value,
   output logic [31:0] rsp_crc_value,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   // configuration
   logic [15:0] word_count_ff, word_count_in;
   logic [31:0] seed_ff, seed_in;

   // run state
   logic [15:0] word_index_ff, word_index_in;
   logic [31:0] expected_ff, expected_in;
   logic [31:0] crc_ff, crc_in;
   logic        found_ff, found_in;
   logic [15:0] bad_index_ff, bad_index_in;
   logic [31:0] bad_got_ff, bad_got_in;
   logic [31:0] bad_want_ff, bad_want_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_fail_index_ff, rsp_fail_index_in;
   logic        rsp_mismatch_ff, rsp_mismatch_in;
   logic [31:0] rsp_got_ff, rsp_got_in;
   logic [31:0] rsp_want_ff, rsp_want_in;
   logic [31:0] rsp_crc_ff, rsp_crc_in;

   logic [31:0] crc_word;
   logic [15:0] run_len;
   logic [16:0] seen;
   logic        last_word;
   logic        req_fire;
   logic        hit_bad;
   logic        found_now;
   logic [15:0] bad_index_now;
   logic [31:0] bad_got_now;
   logic [31:0] bad_want_now;
   logic        base_write;

   pcc_crc32 u_crc (
      .crc_cur  (crc_ff),
      .word     (req_word_data),
      .crc_next (crc_word)
   );

   always_comb begin
      run_len   = (word_count_ff == 16'd0) ? 16'd1 : word_count_ff;
      seen      = {1'b0, word_index_ff} + 17'd1;
      last_word = seen >= {1'b0, run_len};
      req_ready = !last_word || !rsp_valid_ff || rsp_ready;
      req_fire  = req_valid && req_ready;

      hit_bad       = !found_ff && (req_word_data != expected_ff);
      found_now     = found_ff || hit_bad;
      bad_index_now = hit_bad ? word_index_ff : bad_index_ff;
      bad_got_now   = hit_bad ? req_word_data : bad_got_ff;
      bad_want_now  = hit_bad ? expected_ff : bad_want_ff;

      base_write = csr_we && (csr_index == pcc_pkg::CSR_PATTERN_BASE);

      word_count_in   = (csr_we && (csr_index == pcc_pkg::CSR_WORD_COUNT)) ?
                        csr_wdata[15:0] : word_count_ff;
      seed_in         = base_write ?
                        csr_wdata * pcc_pkg::LCG_MUL + pcc_pkg::LCG_ADD : seed_ff;

      word_index_in = word_index_ff;
      expected_in   = expected_ff;
      crc_in        = crc_ff;
      found_in      = found_ff;
      bad_index_in  = bad_index_ff;
      bad_got_in    = bad_got_ff;
      bad_want_in   = bad_want_ff;

      if (req_fire) begin
         if (last_word) begin
            word_index_in = 16'd0;
            expected_in   = seed_ff;
            crc_in        = pcc_pkg::CRC_ONES;
            found_in      = 1'b0;
            bad_index_in  = 16'd0;
            bad_got_in    = 32'd0;
            bad_want_in   = 32'd0;
         end else begin
            word_index_in = seen[15:0];
            expected_in   = expected_ff + pcc_pkg::LCG_MUL;
            crc_in        = crc_word;
            found_in      = found_now;
            bad_index_in  = bad_index_now;
            bad_got_in    = bad_got_now;
            bad_want_in   = bad_want_now;
         end
      end

      // base rewrite reloads the expected word for the current position
      if (base_write) begin
         expected_in = (csr_wdata + {16'd0, word_index_ff}) * pcc_pkg::LCG_MUL
                       + pcc_pkg::LCG_ADD;
      end

      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_fail_index_in = rsp_fail_index_ff;
      rsp_mismatch_in   = rsp_mismatch_ff;
      rsp_got_in        = rsp_got_ff;
      rsp_want_in       = rsp_want_ff;
      rsp_crc_in        = rsp_crc_ff;
      if (req_fire && last_word) begin
         rsp_valid_in      = 1'b1;
         rsp_fail_index_in = found_now ? bad_index_now : run_len;
         rsp_mismatch_in   = found_now;
         rsp_got_in        = bad_got_now;
         rsp_want_in       = bad_want_now;
         rsp_crc_in        = ~crc_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_count_ff   <= pcc_pkg::WORD_COUNT_RESET;
         seed_ff         <= pcc_pkg::LCG_ADD;
         word_index_ff   <= 16'd0;
         expected_ff     <= pcc_pkg::LCG_ADD;
         crc_ff          <= pcc_pkg::CRC_ONES;
         found_ff        <= 1'b0;
         bad_index_ff    <= 16'd0;
         bad_got_ff      <= 32'd0;
         bad_want_ff     <= 32'd0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         word_count_ff   <= word_count_in;
         seed_ff         <= seed_in;
         word_index_ff   <= word_index_in;
         expected_ff     <= expected_in;
         crc_ff          <= crc_in;
         found_ff        <= found_in;
         bad_index_ff    <= bad_index_in;
         bad_got_ff      <= bad_got_in;
         bad_want_ff     <= bad_want_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_fail_index_ff <= rsp_fail_index_in;
      rsp_mismatch_ff   <= rsp_mismatch_in;
      rsp_got_ff        <= rsp_got_in;
      rsp_want_ff       <= rsp_want_in;
      rsp_crc_ff        <= rsp_crc_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_fail_index = rsp_fail_index_ff;
   assign rsp_mismatch   = rsp_mismatch_ff;
   assign rsp_got_value  = rsp_got_ff;
   assign rsp_want_value = rsp_want_ff;
   assign rsp_crc_value  = rsp_crc_ff;

   // a run-ending transaction clears the run state
   assert property (@(posedge clock) disable iff (reset)
      req_fire && last_word |=> word_index_ff == 16'd0 && crc_ff == pcc_pkg::CRC_ONES
                                && !found_ff)
      else $error("run state not cleared after run end");

   // stall on input only while a result is waiting
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid_ff && last_word)
      else $error("input stalled without pending result");

   // clean run reports zero capture values
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_mismatch_ff |-> rsp_got_ff == 32'd0 && rsp_want_ff == 32'd0)
      else $error("clean run reports nonzero capture");

   // captured index never runs ahead of the current position
   assert property (@(posedge clock) disable iff (reset)
      found_ff |-> bad_index_ff <= word_index_ff)
      else $error("captured index beyond current word");

endmodule

[rtl/pcc_crc32.sv]
`timescale 1ns / 1ps
// pcc_crc32: combinational reflected crc32 update over a 32-bit word, low byte first
// depends on pcc_pkg

module pcc_crc32 (
   input  logic [31:0] crc_cur,
   input  logic [31:0] word,
   output logic [31:0] crc_next
);

   logic [31:0] crc_b0;
   logic [31:0] crc_b1;
   logic [31:0] crc_b2;

   always_comb begin
      crc_b0   = pcc_pkg::crc_byte(crc_cur, word[7:0]);
      crc_b1   = pcc_pkg::crc_byte(crc_b0, word[15:8]);
      crc_b2   = pcc_pkg::crc_byte(crc_b1, word[23:16]);
      crc_next = pcc_pkg::crc_byte(crc_b2, word[31:24]);
   end

endmodule

[tb/sv/pcc_run_checker.sv]
`timescale 1ns / 1ps
// pcc_run_checker: watches the word, result and csr ports of the pattern checker,
// predicts every run result and compares it field by field
// depends on pcc_pkg

module pcc_run_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [31:0] req_word_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [15:0] rsp_fail_index,
   input  logic        rsp_mismatch,
   input  logic [31:0] rsp_got_value,
   input  logic [31:0] rsp_want_value,
   input  logic [31:0] rsp_crc_value,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output int          fault_count,
   output int          runs_pending
);

   typedef struct packed {
      logic [15:0] fail_index;
      logic        mismatch;
      logic [31:0] got_value;
      logic [31:0] want_value;
      logic [31:0] crc_value;
   } run_result_type;

   run_result_type pending_results[$];

   // shadow of the csr registers and of the run in progress
   logic [31:0] base_reg;
   logic [15:0] count_reg;
   logic [15:0] word_pos;
   logic [31:0] next_pattern;
   logic [31:0] crc_acc;
   logic        seen_bad;
   logic [15:0] bad_pos;
   logic [31:0] bad_read;
   logic [31:0] bad_expected;

   function automatic logic [31:0] pattern_at(input logic [31:0] idx);
      return idx * pcc_pkg::LCG_MUL + pcc_pkg::LCG_ADD;
   endfunction

   // reflected crc, one bit at a time, lsb of the word first
   function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [31:0] word);
      logic [31:0] c;
      c = crc;
      for (int i = 0; i < 32; i++) begin
         c = (c >> 1) ^ ((c[0] ^ word[i]) ? pcc_pkg::CRC_POLY : 32'd0);
      end
      return c;
   endfunction

   task automatic log_fault(input string line);
      $display("%0t run_check: %s", $time, line);
      fault_count++;
   endtask

   task automatic clear_run();
      word_pos = 16'd0;
      next_pattern = pattern_at(base_reg);
      crc_acc = pcc_pkg::CRC_ONES;
      seen_bad = 1'b0;
      bad_pos = 16'd0;
      bad_read = 32'd0;
      bad_expected = 32'd0;
   endtask

   task automatic fold_word(input logic [31:0] data);
      logic [16:0] seen;
      logic [16:0] run_len;
      run_result_type r;
      if (!seen_bad && data != next_pattern) begin
         seen_bad = 1'b1;
         bad_pos = word_pos;
         bad_read = data;
         bad_expected = next_pattern;
      end
      crc_acc = crc_fold(crc_acc, data);
      seen = {1'b0, word_pos} + 17'd1;
      // a zero count still means a one-word run
      run_len = (count_reg == 16'd0) ? 17'd1 : {1'b0, count_reg};
      if (seen >= run_len) begin
         r.fail_index = seen_bad ? bad_pos : run_len[15:0];
         r.mismatch = seen_bad;
         r.got_value = bad_read;
         r.want_value = bad_expected;
         r.crc_value = ~crc_acc;
         pending_results.push_back(r);
         clear_run();
      end else begin
         word_pos = seen[15:0];
         next_pattern = next_pattern + pcc_pkg::LCG_MUL;
      end
   endtask

   task automatic check_result();
      run_result_type w;
      if (pending_results.size() == 0) begin
         log_fault($sformatf("result with no run pending, crc %h", rsp_crc_value));
      end else begin
         w = pending_results.pop_front();
         if (rsp_fail_index !== w.fail_index)
            log_fault($sformatf("fail_index %0d, want %0d", rsp_fail_index, w.fail_index));
         if (rsp_mismatch !== w.mismatch)
            log_fault($sformatf("mismatch %b, want %b", rsp_mismatch, w.mismatch));
         if (rsp_got_value !== w.got_value)
            log_fault($sformatf("got_value %h, want %h", rsp_got_value, w.got_value));
         if (rsp_want_value !== w.want_value)
            log_fault($sformatf("want_value %h, want %h", rsp_want_value, w.want_value));
         if (rsp_crc_value !== w.crc_value)
            log_fault($sformatf("crc_value %h, want %h", rsp_crc_value, w.crc_value));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         base_reg = 32'd0;
         count_reg = pcc_pkg::WORD_COUNT_RESET;
         clear_run();
         pending_results.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               pcc_pkg::CSR_PATTERN_BASE: begin
                  // a new base takes effect at the current position of the run
                  base_reg = csr_wdata;
                  next_pattern = pattern_at(base_reg + {16'd0, word_pos});
               end
               pcc_pkg::CSR_WORD_COUNT: begin
                  count_reg = csr_wdata[15:0];
               end
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            fold_word(req_word_data);
         end
         if (rsp_valid && rsp_ready) begin
            check_result();
         end
      end
      runs_pending <= pending_results.size();
   end

endmodule

[tb/sv/pattern_check_with_crc32_unit_test.sv]
`timescale 1ns / 1ps
// pattern_check_with_crc32_unit_test: drives read-back words and csr writes into
// the pattern checker and gives the verdict
// depends on pcc_pkg, pcc_run_checker and pattern_check_with_crc32_unit

module pattern_check_with_crc32_unit_test;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_WORDS = 950;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_word_data = 32'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_fail_index;
   logic        rsp_mismatch;
   logic [31:0] rsp_got_value;
   logic [31:0] rsp_want_value;
   logic [31:0] rsp_crc_value;
   logic        csr_we = 1'b0;
   logic [0:0]  csr_index = 1'b0;
   logic [31:0] csr_wdata = 32'd0;

   int fault_count;
   int runs_pending;
   int cycle_count = 0;

   // what the stimulus believes about the run in progress
   logic [31:0] run_base = 32'd0;
   logic [15:0] run_count = pcc_pkg::WORD_COUNT_RESET;
   int          run_pos = 0;
   int          fault_pct = 0;
   bit          steady_send = 1'b0;
   bit          steady_take = 1'b0;
   int          words_sent = 0;

   pattern_check_with_crc32_unit uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_word_data(req_word_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_fail_index(rsp_fail_index),
      .rsp_mismatch(rsp_mismatch),
      .rsp_got_value(rsp_got_value),
      .rsp_want_value(rsp_want_value),
      .rsp_crc_value(rsp_crc_value),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   pcc_run_checker run_check (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_word_data(req_word_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_fail_index(rsp_fail_index),
      .rsp_mismatch(rsp_mismatch),
      .rsp_got_value(rsp_got_value),
      .rsp_want_value(rsp_want_value),
      .rsp_crc_value(rsp_crc_value),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .fault_count(fault_count),
      .runs_pending(runs_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("pattern_check_with_crc32_unit_test: errors");
         $finish;
      end
   end

   // result side: unless steady_take is set, may stall after a transaction and now and then while idle
   always @(posedge clock) begin : take_side
      int hold;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold = 0;
      end else if (rsp_valid && rsp_ready) begin
         hold = steady_take ? 0 : $urandom_range(0, 13);
         if (hold != 0) rsp_ready <= 1'b0;
      end else if (rsp_ready) begin
         if (!steady_take && $urandom_range(0, 7) == 0) begin
            hold = $urandom_range(1, 13);
            rsp_ready <= 1'b0;
         end
      end else if (hold == 0) begin
         rsp_ready <= 1'b1;
      end else begin
         hold--;
      end
   end

   function automatic logic [31:0] pattern_word();
      return (run_base + 32'(run_pos)) * pcc_pkg::LCG_MUL + pcc_pkg::LCG_ADD;
   endfunction

   function automatic logic [31:0] stimulus_word();
      logic [31:0] w;
      w = pattern_word();
      if ($urandom_range(0, 99) < fault_pct) begin
         case ($urandom_range(0, 2))
            0:       w = w ^ (32'd1 << $urandom_range(0, 31));
            1:       w = $urandom();
            default: w = ~w;
         endcase
      end
      return w;
   endfunction

   task automatic push_word(input logic [31:0] data);
      int gap;
      gap = steady_send ? 0 : $urandom_range(0, 13);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word_data <= data;
      do @(posedge clock); while (!req_ready);
      if (run_pos + 1 >= ((run_count == 16'd0) ? 1 : int'(run_count))) run_pos = 0;
      else run_pos++;
   endtask

   // hold the sender until every run result is back and the block is quiet
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (runs_pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input pcc_pkg::csr_index_type idx, input logic [31:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == pcc_pkg::CSR_PATTERN_BASE) run_base = value;
      else run_count = value[15:0];
   endtask

   initial begin : stimulus
      int n;
      int run_len;
      int pick;
      logic [31:0] value;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset settings, error at word 3, then the count drops below the words seen
      repeat (3) push_word(pattern_word());
      push_word(~pattern_word());
      settle();
      write_reg(pcc_pkg::CSR_WORD_COUNT, 32'd2);
      push_word(pattern_word());

      // zero count gives one-word runs
      settle();
      write_reg(pcc_pkg::CSR_PATTERN_BASE, 32'hFFFF_FFFF);
      write_reg(pcc_pkg::CSR_WORD_COUNT, 32'hFFFF_0000);
      push_word(pattern_word());
      push_word(32'h0000_0000);
      push_word(32'hFFFF_FFFF);

      settle();
      write_reg(pcc_pkg::CSR_PATTERN_BASE, 32'd0);
      write_reg(pcc_pkg::CSR_WORD_COUNT, 32'd1);
      push_word(pattern_word());
      push_word(pattern_word() ^ 32'h8000_0000);

      // base changes in the middle of a run
      settle();
      write_reg(pcc_pkg::CSR_WORD_COUNT, 32'd3);
      write_reg(pcc_pkg::CSR_PATTERN_BASE, $urandom());
      push_word(pattern_word());
      settle();
      write_reg(pcc_pkg::CSR_PATTERN_BASE, $urandom());
      push_word(pattern_word());
      push_word(pattern_word() ^ 32'd1);

      // longest count, cut short mid-run
      settle();
      write_reg(pcc_pkg::CSR_WORD_COUNT, 32'h0000_FFFF);
      repeat (2) push_word(pattern_word());
      settle();
      write_reg(pcc_pkg::CSR_WORD_COUNT, 32'd1);
      push_word(pattern_word());

      settle();
      write_reg(pcc_pkg::CSR_PATTERN_BASE, 32'h7FFF_FFFF);
      write_reg(pcc_pkg::CSR_WORD_COUNT, 32'd5);
      repeat (5) push_word(pattern_word());

      while (words_sent < RANDOM_WORDS) begin
         settle();
         steady_send = ($urandom_range(0, 4) == 0);
         steady_take = ($urandom_range(0, 4) == 0);
         case ($urandom_range(0, 2))
            0:       fault_pct = 0;
            1:       fault_pct = 4;
            default: fault_pct = 25;
         endcase
         if ($urandom_range(0, 2) != 0) begin
            pick = $urandom_range(0, 5);
            if (pick == 0) value = 32'd0;
            else if (pick == 1) value = 32'hFFFF_FFFF;
            else value = $urandom();
            write_reg(pcc_pkg::CSR_PATTERN_BASE, value);
         end
         if ($urandom_range(0, 3) != 0) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) value = 32'd0;
            else if (pick < 13) value = $urandom_range(1, 6);
            else if (pick < 18) value = $urandom_range(7, 40);
            else value = $urandom_range(41, 150);
            // upper bits are not part of the register
            value[31:16] = 16'($urandom());
            write_reg(pcc_pkg::CSR_WORD_COUNT, value);
         end
         run_len = (run_count == 16'd0) ? 1 : int'(run_count);
         n = run_len * $urandom_range(1, 3);
         // some phases stop mid-run so the next csr write lands inside a run
         if ($urandom_range(0, 3) == 0) n = n - $urandom_range(0, run_len - 1);
         if (n > RANDOM_WORDS - words_sent) n = RANDOM_WORDS - words_sent;
         repeat (n) begin
            push_word(stimulus_word());
            words_sent++;
         end
      end

      settle();
      if (fault_count == 0 && runs_pending == 0) begin
         $display("pattern_check_with_crc32_unit_test: clean");
      end else begin
         $display("pattern_check_with_crc32_unit_test: errors");
      end
      $finish;
   end

endmodule
